// File: rtl/scheduled_event_timer_table_defines.svh
// Assertion macros for the scheduled event timer table.
// Included by the top level; no other dependencies.
`ifndef SCHEDULED_EVENT_TIMER_TABLE_DEFINES_SVH
`define SCHEDULED_EVENT_TIMER_TABLE_DEFINES_SVH

// implication checked in the same cycle
`define SETB_ASSERT_NOW(label, clk, rstn, a, c) \
  label: assert property (@(posedge clk) disable iff (!rstn) (a) |-> (c)) \
    else $error("setb check failed");

// implication checked in the next cycle
`define SETB_ASSERT_NEXT(label, clk, rstn, a, c) \
  label: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (c)) \
    else $error("setb check failed");

`endif

// File: rtl/setb_pkg.sv
// Types, codes and constants shared by the scheduled event timer table.
// No dependencies.
`default_nettype none
package setb_pkg;
  localparam int DEPTH_DEFAULT = 16;
  localparam logic [15:0] LEAD_RESET = 16'd15;
  localparam logic [15:0] CDEF_RESET = 16'd300;

  localparam logic [2:0] ACT_ADD   = 3'd0;
  localparam logic [2:0] ACT_TICK  = 3'd1;
  localparam logic [2:0] ACT_REM   = 3'd2;
  localparam logic [2:0] ACT_MARK  = 3'd3;
  localparam logic [2:0] ACT_CLEAR = 3'd4;
  localparam logic [2:0] ACT_CONFL = 3'd5;

  localparam logic [2:0] RK_DONE   = 3'd0;
  localparam logic [2:0] RK_ADDED  = 3'd1;
  localparam logic [2:0] RK_FULL   = 3'd2;
  localparam logic [2:0] RK_SWITCH = 3'd3;
  localparam logic [2:0] RK_RECORD = 3'd4;
  localparam logic [2:0] RK_CONF   = 3'd5;
  localparam logic [2:0] RK_NOCONF = 3'd6;

  localparam logic [7:0] REG_LEAD = 8'd0;
  localparam logic [7:0] REG_CDEF = 8'd1;

  typedef struct packed {
    logic [2:0]  action;
    logic [39:0] now_seconds;
    logic [39:0] start_seconds;
    logic [15:0] duration_minutes;
    logic [1:0]  timer_kind;
    logic [15:0] service_ref;
    logic [15:0] channel_ref;
    logic [15:0] title_ref;
    logic [15:0] entry_id;
  } setb_in_t;

  typedef struct packed {
    logic [2:0]  result_kind;
    logic [15:0] out_id;
    logic [15:0] out_service;
    logic [15:0] out_channel;
    logic [15:0] out_duration;
    logic [15:0] out_title;
    logic [3:0]  conflict_row;
    logic        last;
  } setb_out_t;

  typedef struct packed {
    logic [39:0] start;
    logic [15:0] len;
    logic [1:0]  kind;
    logic [15:0] svc;
    logic [15:0] chn;
    logic [15:0] title;
    logic [15:0] id;
    logic        fired;
  } setb_entry_t;

  // minutes to seconds: m*64 - m*4
  function automatic logic [21:0] min_to_sec(input logic [15:0] m);
    min_to_sec = {m, 6'b0} - {4'b0, m, 2'b0};
  endfunction
endpackage
`default_nettype wire

// File: rtl/setb_ram.sv
// Entry memory of the timer table: one write and one registered read port.
// Depends on setb_pkg.
`default_nettype none
module setb_ram import setb_pkg::*; #(
  parameter int DEPTH = DEPTH_DEFAULT,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic        clk,
  input  wire logic        we,
  input  wire logic [AW-1:0] waddr,
  input  wire setb_entry_t wdata,
  input  wire logic        re,
  input  wire logic [AW-1:0] raddr,
  output setb_entry_t      rdata
);
  setb_entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule
`default_nettype wire

// File: rtl/scheduled_event_timer_table.sv
// Scheduled event timer table, top level. Depends on setb_pkg, setb_ram.
// One item at a time; in_ready only when idle. Walk actions visit each entry
// with a memory read, then evaluate/write back; add walks back from the tail,
// shifting each later entry up one row until the new entry's slot is found.
// Tick fire beats stall the walk while the output register is full.
// Synchronous active-low reset empties the table and reloads the registers.
`default_nettype none
`include "scheduled_event_timer_table_defines.svh"
module scheduled_event_timer_table import setb_pkg::*; #(
  parameter int TABLE_DEPTH = DEPTH_DEFAULT
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire setb_in_t  in_data,
  output logic           out_valid,
  input  wire logic      out_ready,
  output setb_out_t      out_data,
  input  wire logic      cfg_valid,
  output logic           cfg_ready,
  input  wire logic [7:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);
  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(TABLE_DEPTH);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RD   = 2'd1;
  localparam logic [1:0] ST_EV   = 2'd2;
  localparam logic [1:0] ST_FIN  = 2'd3;

  logic [1:0]    state_r, state_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt, i_r, i_nxt, w_r, w_nxt;
  logic          found_r, found_nxt;
  setb_in_t      item_r, item_nxt;
  logic [40:0]   new_end_r, new_end_nxt;
  logic [15:0]   id_ctr_r, id_ctr_nxt, lead_r, cdef_r;
  logic [2:0]    fin_kind_r, fin_kind_nxt;
  logic [15:0]   fin_id_r, fin_id_nxt;
  logic [3:0]    fin_row_r, fin_row_nxt;
  logic          out_valid_r, out_valid_nxt;
  setb_out_t     out_r, out_nxt;

  logic          we, re;
  logic [AW-1:0] waddr, raddr;
  setb_entry_t   wdata, e, new_e, e_upd;

  logic [21:0] in_span, e_len60;
  logic [40:0] e_end, e_cend, now_lead, now41, e_start41;
  logic        out_free, due, keep, fire, ov, match;

  setb_ram #(.DEPTH(TABLE_DEPTH)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
    .re(re), .raddr(raddr), .rdata(e)
  );

  assign in_ready  = (state_r == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign out_free  = !out_valid_r || out_ready;

  always_comb begin
    new_e.start = item_r.start_seconds;
    new_e.len   = item_r.duration_minutes;
    new_e.kind  = item_r.timer_kind;
    new_e.svc   = item_r.service_ref;
    new_e.chn   = item_r.channel_ref;
    new_e.title = item_r.title_ref;
    new_e.id    = id_ctr_r;
    new_e.fired = 1'b0;
  end

  assign in_span   = min_to_sec(in_data.duration_minutes);
  assign e_len60   = min_to_sec(e.len);
  assign e_start41 = {1'b0, e.start};
  assign now41     = {1'b0, item_r.now_seconds};
  assign e_end     = e_start41 + 41'(e_len60);
  assign e_cend    = e_start41 + ((e.len != 16'd0) ? 41'(e_len60) : 41'(cdef_r));
  assign now_lead  = now41 + 41'(lead_r);
  assign due       = e_start41 <= now_lead;
  assign ov        = ({1'b0, item_r.start_seconds} < e_cend) && (new_end_r > e_start41);
  assign match     = !found_r && (e.id == item_r.entry_id);

  always_comb begin
    keep  = 1'b1;
    fire  = 1'b0;
    e_upd = e;
    unique case (item_r.action)
      ACT_TICK: begin
        if (e.fired) begin
          keep = !(now41 >= e_end);
        end else if (due) begin
          if (e.len != 16'd0 && now41 >= e_end) begin
            keep = 1'b0;
          end else begin
            fire = 1'b1;
            keep = e.kind[0];
            e_upd.fired = 1'b1;
          end
        end
      end
      ACT_REM:  keep = !match;
      ACT_MARK: if (match) e_upd.fired = 1'b1;
      default: ;
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    i_nxt         = i_r;
    w_nxt         = w_r;
    found_nxt     = found_r;
    item_nxt      = item_r;
    new_end_nxt   = new_end_r;
    id_ctr_nxt    = id_ctr_r;
    fin_kind_nxt  = fin_kind_r;
    fin_id_nxt    = fin_id_r;
    fin_row_nxt   = fin_row_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_nxt       = out_r;
    we    = 1'b0;
    re    = 1'b0;
    waddr = '0;
    raddr = '0;
    wdata = new_e;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          item_nxt     = in_data;
          i_nxt        = '0;
          w_nxt        = '0;
          found_nxt    = 1'b0;
          fin_kind_nxt = RK_DONE;
          fin_id_nxt   = '0;
          fin_row_nxt  = '0;
          new_end_nxt  = {1'b0, in_data.start_seconds} +
            ((in_data.duration_minutes != 16'd0) ? 41'(in_span) : 41'(cdef_r));
          state_nxt    = ST_FIN;
          priority case (in_data.action)
            ACT_ADD: begin
              if (cnt_r == FULL_CNT) begin
                fin_kind_nxt = RK_FULL;
              end else begin
                id_ctr_nxt   = id_ctr_r + 16'd1;
                fin_kind_nxt = RK_ADDED;
                fin_id_nxt   = id_ctr_r + 16'd1;
                cnt_nxt      = cnt_r + CW'(1);
                i_nxt        = cnt_r;
                state_nxt    = ST_RD;
              end
            end
            ACT_TICK, ACT_REM, ACT_MARK: state_nxt = ST_RD;
            ACT_CONFL: begin
              fin_kind_nxt = RK_NOCONF;
              state_nxt    = ST_RD;
            end
            ACT_CLEAR: cnt_nxt = '0;
            default: ;
          endcase
        end
      end
      ST_RD: begin
        if (item_r.action == ACT_ADD) begin
          if (i_r == '0) begin
            we        = 1'b1;
            state_nxt = ST_FIN;
          end else begin
            re        = 1'b1;
            raddr     = AW'(i_r - CW'(1));
            state_nxt = ST_EV;
          end
        end else if (i_r == cnt_r) begin
          if (item_r.action != ACT_CONFL) cnt_nxt = w_r;
          state_nxt = ST_FIN;
        end else begin
          re        = 1'b1;
          raddr     = i_r[AW-1:0];
          state_nxt = ST_EV;
        end
      end
      ST_EV: begin
        if (item_r.action == ACT_ADD) begin
          we    = 1'b1;
          waddr = i_r[AW-1:0];
          if (e.start > item_r.start_seconds) begin
            wdata     = e;
            i_nxt     = i_r - CW'(1);
            state_nxt = ST_RD;
          end else begin
            state_nxt = ST_FIN;
          end
        end else if (item_r.action == ACT_CONFL) begin
          if (ov) begin
            fin_kind_nxt = RK_CONF;
            fin_row_nxt  = 4'(i_r);
            state_nxt    = ST_FIN;
          end else begin
            i_nxt     = i_r + CW'(1);
            state_nxt = ST_RD;
          end
        end else if (!fire || out_free) begin
          if (fire) begin
            out_valid_nxt        = 1'b1;
            out_nxt.result_kind  = e.kind[0] ? RK_RECORD : RK_SWITCH;
            out_nxt.out_id       = e.id;
            out_nxt.out_service  = e.svc;
            out_nxt.out_channel  = e.chn;
            out_nxt.out_duration = e.len;
            out_nxt.out_title    = e.kind[0] ? e.title : 16'd0;
            out_nxt.conflict_row = '0;
            out_nxt.last         = 1'b0;
          end
          if (match) found_nxt = 1'b1;
          if (keep) begin
            we    = 1'b1;
            waddr = w_r[AW-1:0];
            wdata = e_upd;
            w_nxt = w_r + CW'(1);
          end
          i_nxt     = i_r + CW'(1);
          state_nxt = ST_RD;
        end
      end
      ST_FIN: begin
        if (out_free) begin
          out_valid_nxt        = 1'b1;
          out_nxt.result_kind  = fin_kind_r;
          out_nxt.out_id       = fin_id_r;
          out_nxt.out_service  = '0;
          out_nxt.out_channel  = '0;
          out_nxt.out_duration = '0;
          out_nxt.out_title    = '0;
          out_nxt.conflict_row = fin_row_r;
          out_nxt.last         = 1'b1;
          state_nxt            = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      id_ctr_r    <= '0;
      out_valid_r <= 1'b0;
      lead_r      <= LEAD_RESET;
      cdef_r      <= CDEF_RESET;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      id_ctr_r    <= id_ctr_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_index == REG_LEAD) lead_r <= cfg_data;
      if (cfg_valid && cfg_index == REG_CDEF) cdef_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    i_r        <= i_nxt;
    w_r        <= w_nxt;
    found_r    <= found_nxt;
    item_r     <= item_nxt;
    new_end_r  <= new_end_nxt;
    fin_kind_r <= fin_kind_nxt;
    fin_id_r   <= fin_id_nxt;
    fin_row_r  <= fin_row_nxt;
    out_r      <= out_nxt;
  end

  `SETB_ASSERT_NOW(a_cnt_bound, clk, rst_n, 1'b1, cnt_r <= FULL_CNT)
  `SETB_ASSERT_NEXT(a_clear_empties, clk, rst_n,
    in_valid && in_ready && in_data.action == ACT_CLEAR, cnt_r == '0)
  `SETB_ASSERT_NOW(a_walk_bound, clk, rst_n,
    state_r == ST_RD && item_r.action != ACT_ADD, w_r <= i_r && i_r <= cnt_r)
endmodule
`default_nettype wire

// File: test/tb_scheduled_event_timer_table.sv
// Testbench for the scheduled event timer table: drives actions and register
// writes over valid/ready, predicts every result beat and compares them.
// Depends on setb_pkg and the scheduled_event_timer_table RTL.
`timescale 1ns / 1ps
module tb_scheduled_event_timer_table;
  import setb_pkg::*;

  localparam int DEPTH = 16;
  localparam int STALL_LIMIT = 20000;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  setb_in_t in_data;
  logic out_valid;
  logic out_ready;
  setb_out_t out_data;
  logic cfg_valid;
  logic cfg_ready;
  logic [7:0] cfg_index;
  logic [15:0] cfg_data;

  scheduled_event_timer_table dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // predicted table
  setb_entry_t sched [DEPTH];
  int unsigned sched_cnt;
  logic [15:0] next_id;
  logic [15:0] lead_s;
  logic [15:0] cdef_s;
  setb_out_t pending_beats[$];
  int errors;
  int idle_cycles;
  bit timed_out;

  function automatic logic [41:0] span_sec(input logic [15:0] m);
    return 42'(m) * 42'd60;
  endfunction

  function automatic setb_out_t beat(input logic [2:0] k, input logic [15:0] id,
                                     input logic [3:0] row, input logic lst);
    setb_out_t b;
    b = '0;
    b.result_kind = k;
    b.out_id = id;
    b.conflict_row = row;
    b.last = lst;
    return b;
  endfunction

  task automatic queue_beat(input setb_out_t b);
    pending_beats.insert(pending_beats.size(), b);
  endtask

  task automatic predict_schedule(input setb_in_t it);
    setb_entry_t kept [DEPTH];
    setb_out_t b;
    logic [41:0] e_end, n_end, sp;
    int unsigned pos, w;
    bit hit, drop;
    case (it.action)
      ACT_ADD: begin
        if (sched_cnt >= DEPTH) begin
          queue_beat(beat(RK_FULL, 16'd0, 4'd0, 1'b1));
        end else begin
          next_id = next_id + 16'd1;
          pos = 0;
          while (pos < sched_cnt && sched[pos].start <= it.start_seconds) pos++;
          for (int i = sched_cnt; i > pos; i--) sched[i] = sched[i-1];
          sched[pos] = '{it.start_seconds, it.duration_minutes, it.timer_kind,
                         it.service_ref, it.channel_ref, it.title_ref, next_id, 1'b0};
          sched_cnt++;
          queue_beat(beat(RK_ADDED, next_id, 4'd0, 1'b1));
        end
      end
      ACT_TICK: begin
        w = 0;
        for (int i = 0; i < sched_cnt; i++) begin
          drop = 1'b0;
          e_end = 42'(sched[i].start) + span_sec(sched[i].len);
          if (sched[i].fired) begin
            drop = (42'(it.now_seconds) >= e_end);
          end else if (42'(sched[i].start) <= 42'(it.now_seconds) + 42'(lead_s)) begin
            if (sched[i].len != 0 && 42'(it.now_seconds) >= e_end) begin
              drop = 1'b1;
            end else begin
              b = '0;
              b.out_id = sched[i].id;
              b.out_service = sched[i].svc;
              b.out_channel = sched[i].chn;
              b.out_duration = sched[i].len;
              if (sched[i].kind[0]) begin
                b.result_kind = RK_RECORD;
                b.out_title = sched[i].title;
                sched[i].fired = 1'b1;
              end else begin
                b.result_kind = RK_SWITCH;
                drop = 1'b1;
              end
              queue_beat(b);
            end
          end
          if (!drop) begin
            kept[w] = sched[i];
            w++;
          end
        end
        for (int i = 0; i < w; i++) sched[i] = kept[i];
        sched_cnt = w;
        queue_beat(beat(RK_DONE, 16'd0, 4'd0, 1'b1));
      end
      ACT_REM, ACT_MARK: begin
        for (int i = 0; i < sched_cnt; i++) begin
          if (sched[i].id == it.entry_id) begin
            if (it.action == ACT_MARK) begin
              sched[i].fired = 1'b1;
            end else begin
              for (int j = i; j + 1 < sched_cnt; j++) sched[j] = sched[j+1];
              sched_cnt--;
            end
            break;
          end
        end
        queue_beat(beat(RK_DONE, 16'd0, 4'd0, 1'b1));
      end
      ACT_CLEAR: begin
        sched_cnt = 0;
        queue_beat(beat(RK_DONE, 16'd0, 4'd0, 1'b1));
      end
      ACT_CONFL: begin
        hit = 1'b0;
        sp = (it.duration_minutes != 0) ? span_sec(it.duration_minutes) : 42'(cdef_s);
        n_end = 42'(it.start_seconds) + sp;
        for (int i = 0; i < sched_cnt && !hit; i++) begin
          sp = (sched[i].len != 0) ? span_sec(sched[i].len) : 42'(cdef_s);
          e_end = 42'(sched[i].start) + sp;
          if (42'(it.start_seconds) < e_end && n_end > 42'(sched[i].start)) begin
            hit = 1'b1;
            queue_beat(beat(RK_CONF, 16'd0, 4'(i), 1'b1));
          end
        end
        if (!hit) queue_beat(beat(RK_NOCONF, 16'd0, 4'd0, 1'b1));
      end
      default: queue_beat(beat(RK_DONE, 16'd0, 4'd0, 1'b1));
    endcase
  endtask

  function automatic int gap_len();
    int n;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 2);
    if ($urandom_range(0, 3) == 0) n = 0;
    return n;
  endfunction

  // valid stays up into the next beat when there is no gap
  task automatic send_action(input setb_in_t it);
    int n;
    n = gap_len();
    if (n != 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (!in_ready);
    predict_schedule(it);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_beats.size() != 0 && !timed_out) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic write_reg(input logic [7:0] idx, input logic [15:0] val);
    drain();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == REG_LEAD) lead_s = val;
    else if (idx == REG_CDEF) cdef_s = val;
  endtask

  function automatic setb_in_t mk(input logic [2:0] act);
    setb_in_t it;
    it = '0;
    it.action = act;
    return it;
  endfunction

  function automatic setb_in_t mk_add(input logic [39:0] st, input logic [15:0] dur,
                                      input logic [1:0] kind);
    setb_in_t it;
    logic [191:0] rnd;
    rnd = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    it = rnd[$bits(setb_in_t)-1:0];
    it.action = ACT_ADD;
    it.start_seconds = st;
    it.duration_minutes = dur;
    it.timer_kind = kind;
    return it;
  endfunction

  function automatic setb_in_t mk_tick(input logic [39:0] now);
    setb_in_t it;
    it = mk(ACT_TICK);
    it.now_seconds = now;
    return it;
  endfunction

  function automatic setb_in_t mk_conf(input logic [39:0] st, input logic [15:0] dur);
    setb_in_t it;
    it = mk(ACT_CONFL);
    it.start_seconds = st;
    it.duration_minutes = dur;
    return it;
  endfunction

  function automatic setb_in_t mk_id(input logic [2:0] act, input logic [15:0] id);
    setb_in_t it;
    it = mk(act);
    it.entry_id = id;
    return it;
  endfunction

  task automatic test_directed();
    setb_in_t it;
    send_action(mk_add(40'd1000, 16'd0, 2'd0));
    send_action(mk_add(40'd1000, 16'd5, 2'd1));
    send_action(mk_add(40'hFF_FFFF_FFFF, 16'hFFFF, 2'd3));
    send_action(mk_add(40'd0, 16'd1, 2'd2));
    send_action(mk_conf(40'd990, 16'd0));
    send_action(mk_conf(40'd5000, 16'd1));
    send_action(mk_conf(40'hFF_FFFF_FFFF, 16'hFFFF));
    send_action(mk_id(ACT_MARK, 16'd2));
    send_action(mk_id(ACT_REM, 16'd77));
    send_action(mk_id(ACT_MARK, 16'hFFFF));
    send_action(mk_tick(40'd990));
    send_action(mk_tick(40'd100000));
    send_action(mk_id(ACT_REM, 16'd3));
    it = mk(3'd6);
    it.now_seconds = '1;
    send_action(it);
    it = mk(3'd7);
    send_action(it);
    for (int i = 0; i < DEPTH + 1; i++)
      send_action(mk_add(40'(i * 7), 16'(i), 2'(i)));
    send_action(mk(ACT_CLEAR));
    send_action(mk_tick(40'hFF_FFFF_FFFF));
  endtask

  // random content around a moving clock; most items are adds and ticks
  task automatic test_random(input int count);
    setb_in_t it;
    logic [39:0] base;
    logic [191:0] rnd;
    base = {$urandom, $urandom};
    for (int n = 0; n < count; n++) begin
      rnd = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
      it = rnd[$bits(setb_in_t)-1:0];
      if ($urandom_range(0, 7) != 0) begin
        it.start_seconds = base + 40'($urandom_range(0, 4000));
        it.now_seconds = base + 40'($urandom_range(0, 3000));
        if ($urandom_range(0, 2) != 0) it.duration_minutes = 16'($urandom_range(0, 60));
        if ($urandom_range(0, 1)) it.entry_id = next_id - 16'($urandom_range(0, 16));
        case ($urandom_range(0, 19))
          0, 1, 2, 3, 4, 5, 6: it.action = ACT_ADD;
          7, 8, 9, 10: it.action = ACT_TICK;
          11, 12: it.action = ACT_REM;
          13, 14: it.action = ACT_MARK;
          15: it.action = ACT_CLEAR;
          default: it.action = ACT_CONFL;
        endcase
        if (it.action == ACT_TICK) base = base + 40'($urandom_range(0, 400));
      end
      send_action(it);
    end
  endtask

  // entries sharing one start time keep their insertion order
  task automatic test_same_start();
    send_action(mk(ACT_CLEAR));
    for (int n = 0; n < 4; n++) send_action(mk_add(40'd500, 16'(n), 2'(n)));
    send_action(mk_add(40'd400, 16'd0, 2'd1));
    send_action(mk_conf(40'd500, 16'd0));
    send_action(mk_tick(40'd500));
    send_action(mk_tick(40'd1000));
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_ready = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    sched_cnt = 0;
    next_id = '0;
    lead_s = LEAD_RESET;
    cdef_s = CDEF_RESET;
    errors = 0;
    timed_out = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    write_reg(REG_LEAD, 16'd0);
    write_reg(REG_CDEF, 16'd0);
    test_random(50);
    drain();
    write_reg(REG_LEAD, 16'hFFFF);
    write_reg(REG_CDEF, 16'hFFFF);
    test_random(50);
    write_reg(REG_LEAD, 16'($urandom_range(0, 600)));
    write_reg(REG_CDEF, 16'($urandom));
    test_random(110);
    write_reg(REG_LEAD, LEAD_RESET);
    write_reg(REG_CDEF, CDEF_RESET);
    test_same_start();
    drain();
    if (errors == 0 && pending_beats.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // output side: random stall, compare each beat with the oldest prediction
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (pending_beats.size() == 0) begin
          errors++;
          $display("%0t unexpected beat: actual %p", $realtime, out_data);
        end else if (out_data !== pending_beats[0]) begin
          errors++;
          $display("%0t mismatch: expected %p actual %p", $realtime,
                   pending_beats[0], out_data);
          void'(pending_beats.pop_front());
        end else begin
          void'(pending_beats.pop_front());
        end
      end
      out_ready <= ($urandom_range(0, 9) == 0) ? 1'b0 :
                   ($urandom_range(0, 3) != 0);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        timed_out = 1'b1;
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end
endmodule
